// File: rtl/mtt_pkg.sv
// mtt_pkg: shared widths, command and event codes, register indexes and
// the control/status structs of the marker track table.
// Depends on nothing; every other file of the block imports it.
package mtt_pkg;

    // fixed field widths
    localparam int MARKER_ID_W = 12;
    localparam int POS_W       = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int MISS_W      = 8;
    localparam int DIST_W      = 34;
    localparam int KEEP_W      = 8;
    localparam int CMD_W       = 2;
    localparam int EV_W        = 2;
    localparam int CFG_DATA_W  = 34;
    localparam int CFG_INDEX_W = 1;

    // parameter defaults
    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int DEFAULT_ID_BITS     = 12;

    // register reset values and limits
    localparam logic [DIST_W-1:0] DIST_RESET = 34'd786432;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 8'd10;
    localparam logic [MISS_W-1:0] MISS_MAX   = 8'd255;

    // command codes
    localparam logic [CMD_W-1:0] CMD_FRAME_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DETECT      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME_END   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP        = 2'd3;

    // event codes
    localparam logic [EV_W-1:0] EV_DETECTED = 2'd0;
    localparam logic [EV_W-1:0] EV_POSE     = 2'd1;
    localparam logic [EV_W-1:0] EV_LOST     = 2'd2;
    localparam logic [EV_W-1:0] EV_DROPPED  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIST = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP     = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic issue;
        logic finish;
    } mtt_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic last_addr;
        logic pipe_empty;
    } mtt_status_t;

endpackage

// File: rtl/mtt_controller.sv
// mtt_controller: sequencer of the marker track table (idle, scan, drain,
// finish). Depends on mtt_pkg for the control and status structs.
module mtt_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mtt_pkg::mtt_status_t status,
    output mtt_pkg::mtt_ctl_t    ctl,
    output logic                 busy
);
    import mtt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_addr)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands to the datapath
    always_comb
    begin
        ctl.capture = (state_reg == ST_IDLE) && start;
        ctl.issue   = (state_reg == ST_SCAN);
        ctl.finish  = (state_reg == ST_DONE);
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: rtl/mtt_datapath.sv
// mtt_datapath: entry record memory, valid/detected flags, scan pipeline
// (read, square, gate compare), event output register and config registers.
// Depends on mtt_pkg; driven by mtt_controller through mtt_ctl_t.
module mtt_datapath #(
    parameter int TABLE_DEPTH = mtt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ID_BITS     = mtt_pkg::DEFAULT_ID_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mtt_pkg::mtt_ctl_t                     ctl,
    output mtt_pkg::mtt_status_t                  status,
    input  logic        [mtt_pkg::CMD_W-1:0]       cmd,
    input  logic        [mtt_pkg::MARKER_ID_W-1:0] marker_id,
    input  logic signed [mtt_pkg::POS_W-1:0]       pos_x,
    input  logic signed [mtt_pkg::POS_W-1:0]       pos_y,
    input  logic                                  cfg_we,
    input  logic        [mtt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [mtt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  result_valid,
    output logic        [mtt_pkg::EV_W-1:0]        event_res,
    output logic        [mtt_pkg::SLOT_OUT_W-1:0]  slot,
    output logic        [mtt_pkg::MARKER_ID_W-1:0] ev_marker_id,
    output logic signed [mtt_pkg::POS_W-1:0]       ev_pos_x,
    output logic signed [mtt_pkg::POS_W-1:0]       ev_pos_y,
    output logic                                  last
);
    import mtt_pkg::*;

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ID_W   = (ID_BITS < MARKER_ID_W) ? ID_BITS : MARKER_ID_W;
    localparam int REC_W  = ID_W + 2 * POS_W + MISS_W;
    localparam int MISS_LSB = 0;
    localparam int Y_LSB    = MISS_W;
    localparam int X_LSB    = MISS_W + POS_W;
    localparam int ID_LSB   = MISS_W + 2 * POS_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    // captured item and configuration
    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [POS_W-1:0]  px_reg;
    logic [POS_W-1:0]  py_reg;
    logic [DIST_W-1:0] max_dist_reg;
    logic [KEEP_W-1:0] keep_reg;

    // table storage
    logic [REC_W-1:0]       mem [TABLE_DEPTH];
    logic [REC_W-1:0]       rd_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] det_reg;

    // scan pipeline
    logic [SLOT_W-1:0]  addr_reg;
    logic               s1_valid_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic               s2_valid_reg;
    logic [SLOT_W-1:0]  s2_slot_reg;
    logic               s2_live_reg;
    logic               s2_det_reg;
    logic               s2_idm_reg;
    logic [2*POS_W-1:0] sqx_reg;
    logic [2*POS_W-1:0] sqy_reg;

    // association trackers
    logic               best_found_reg;
    logic [SLOT_W-1:0]  best_slot_reg;
    logic [DIST_W-1:0]  best_d_reg;
    logic               revive_found_reg;
    logic [SLOT_W-1:0]  revive_slot_reg;
    logic               free_found_reg;
    logic [SLOT_W-1:0]  free_slot_reg;

    // held lost event, flushed with last set at the end of a scan
    logic               pend_valid_reg;
    logic [SLOT_W-1:0]  pend_slot_reg;
    logic [ID_W-1:0]    pend_id_reg;
    logic [POS_W-1:0]   pend_x_reg;
    logic [POS_W-1:0]   pend_y_reg;

    // output register
    logic               res_valid_reg;
    logic [EV_W-1:0]    res_ev_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [POS_W-1:0]   res_x_reg;
    logic [POS_W-1:0]   res_y_reg;
    logic               res_last_reg;

    // combinational
    logic               s1_live;
    logic               s1_det;
    logic [ID_W-1:0]    s1_ident;
    logic [POS_W-1:0]   s1_x;
    logic [POS_W-1:0]   s1_y;
    logic [MISS_W-1:0]  s1_misses;
    logic [POS_W:0]     dx;
    logic [POS_W:0]     dy;
    logic [POS_W:0]     adx;
    logic [POS_W:0]     ady;
    logic [2*POS_W-1:0] sqx_next;
    logic [2*POS_W-1:0] sqy_next;
    logic [DIST_W-1:0]  dist_sum;
    logic               inc_hit;
    logic               lost_hit;
    logic               emit_lost;
    logic               fin_detect;
    logic               fin_write;
    logic [SLOT_W-1:0]  fin_slot;
    logic [EV_W-1:0]    fin_ev;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [REC_W-1:0]   wr_data;
    logic               res_valid_next;
    logic [EV_W-1:0]    res_ev_next;
    logic [SLOT_W-1:0]  res_slot_next;
    logic [ID_W-1:0]    res_id_next;
    logic [POS_W-1:0]   res_x_next;
    logic [POS_W-1:0]   res_y_next;
    logic               res_last_next;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;
    logic [ID_W+MARKER_ID_W-1:0]  id_wide;

    // item capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= CMD_FRAME_START;
        end
        else if (ctl.capture)
        begin
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            id_reg <= marker_id[ID_W-1:0];
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= DIST_RESET;
            keep_reg     <= KEEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_DIST: max_dist_reg <= cfg_data[DIST_W-1:0];
                CFG_KEEP:     keep_reg     <= cfg_data[KEEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // scan address and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                addr_reg <= '0;
            end
            else if (ctl.issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_comb
    begin
        status.last_addr  = (addr_reg == LAST_SLOT);
        status.pipe_empty = !s1_valid_reg && !s2_valid_reg;
    end

    // record memory: registered read, one write port
    always_ff @(posedge clk)
    begin
        rd_reg      <= mem[addr_reg];
        s1_slot_reg <= addr_reg;
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // stage 1 decode of the read record
    always_comb
    begin
        s1_live   = valid_reg[s1_slot_reg];
        s1_det    = det_reg[s1_slot_reg];
        s1_ident  = rd_reg[ID_LSB +: ID_W];
        s1_x      = rd_reg[X_LSB +: POS_W];
        s1_y      = rd_reg[Y_LSB +: POS_W];
        s1_misses = rd_reg[MISS_LSB +: MISS_W];
    end

    // stage 1 absolute differences and squares
    always_comb
    begin
        dx  = {s1_x[POS_W-1], s1_x} - {px_reg[POS_W-1], px_reg};
        dy  = {s1_y[POS_W-1], s1_y} - {py_reg[POS_W-1], py_reg};
        adx = dx[POS_W] ? (~dx + 1'b1) : dx;
        ady = dy[POS_W] ? (~dy + 1'b1) : dy;
        sqx_next = adx[POS_W-1:0] * adx[POS_W-1:0];
        sqy_next = ady[POS_W-1:0] * ady[POS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        s2_slot_reg <= s1_slot_reg;
        s2_live_reg <= s1_live;
        s2_det_reg  <= s1_det;
        s2_idm_reg  <= (s1_ident == id_reg);
    end

    // stage 1 frame start aging and lost detection
    always_comb
    begin
        inc_hit  = s1_valid_reg && (cmd_reg == CMD_FRAME_START) && s1_live && s1_det
                   && (s1_misses != MISS_MAX);
        lost_hit = s1_valid_reg && (cmd_reg == CMD_FRAME_END) && s1_live && s1_det
                   && (s1_misses >= keep_reg);
        emit_lost = lost_hit
                    || (s1_valid_reg && (cmd_reg == CMD_STOP) && s1_live && s1_det);
    end

    // stage 2 nearest gated match, first undetected and first free slot
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg   <= 1'b0;
            revive_found_reg <= 1'b0;
            free_found_reg   <= 1'b0;
        end
        else if (ctl.capture)
        begin
            best_found_reg   <= 1'b0;
            revive_found_reg <= 1'b0;
            free_found_reg   <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_live_reg && s2_det_reg && s2_idm_reg && (dist_sum < max_dist_reg)
                && (!best_found_reg || (dist_sum < best_d_reg)))
            begin
                best_found_reg <= 1'b1;
            end
            if (s2_live_reg && s2_idm_reg && !s2_det_reg)
            begin
                revive_found_reg <= 1'b1;
            end
            if (!s2_live_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            if (s2_live_reg && s2_det_reg && s2_idm_reg && (dist_sum < max_dist_reg)
                && (!best_found_reg || (dist_sum < best_d_reg)))
            begin
                best_slot_reg <= s2_slot_reg;
                best_d_reg    <= dist_sum;
            end
            if (s2_live_reg && s2_idm_reg && !s2_det_reg && !revive_found_reg)
            begin
                revive_slot_reg <= s2_slot_reg;
            end
            if (!s2_live_reg && !free_found_reg)
            begin
                free_slot_reg <= s2_slot_reg;
            end
        end
    end

    // detection outcome at finish
    always_comb
    begin
        fin_detect = ctl.finish && (cmd_reg == CMD_DETECT);
        fin_write  = 1'b1;
        if (best_found_reg)
        begin
            fin_ev   = EV_POSE;
            fin_slot = best_slot_reg;
        end
        else if (revive_found_reg)
        begin
            fin_ev   = EV_DETECTED;
            fin_slot = revive_slot_reg;
        end
        else if (free_found_reg)
        begin
            fin_ev   = EV_DETECTED;
            fin_slot = free_slot_reg;
        end
        else
        begin
            fin_ev    = EV_DROPPED;
            fin_slot  = '0;
            fin_write = 1'b0;
        end
    end

    // memory write port select
    always_comb
    begin
        wr_en = inc_hit || (fin_detect && fin_write);
        if (ctl.finish)
        begin
            wr_addr = fin_slot;
            wr_data = {id_reg, px_reg, py_reg, MISS_W'(0)};
        end
        else
        begin
            wr_addr = s1_slot_reg;
            wr_data = {s1_ident, s1_x, s1_y, s1_misses + 1'b1};
        end
    end

    // valid and detected flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            det_reg   <= '0;
        end
        else if (ctl.finish && (cmd_reg == CMD_STOP))
        begin
            valid_reg <= '0;
            det_reg   <= '0;
        end
        else if (fin_detect && fin_write)
        begin
            valid_reg[fin_slot] <= 1'b1;
            det_reg[fin_slot]   <= 1'b1;
        end
        else if (lost_hit)
        begin
            det_reg[s1_slot_reg] <= 1'b0;
        end
    end

    // held lost event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (ctl.capture || ctl.finish)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (emit_lost)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_lost)
        begin
            pend_slot_reg <= s1_slot_reg;
            pend_id_reg   <= s1_ident;
            pend_x_reg    <= s1_x;
            pend_y_reg    <= s1_y;
        end
    end

    // next result transfer
    always_comb
    begin
        res_valid_next = 1'b0;
        res_ev_next    = EV_LOST;
        res_slot_next  = pend_slot_reg;
        res_id_next    = pend_id_reg;
        res_x_next     = pend_x_reg;
        res_y_next     = pend_y_reg;
        res_last_next  = 1'b1;
        if (fin_detect)
        begin
            res_valid_next = 1'b1;
            res_ev_next    = fin_ev;
            res_slot_next  = fin_slot;
            res_id_next    = id_reg;
            res_x_next     = px_reg;
            res_y_next     = py_reg;
        end
        else if (ctl.finish)
        begin
            res_valid_next = pend_valid_reg;
        end
        else if (emit_lost && pend_valid_reg)
        begin
            res_valid_next = 1'b1;
            res_last_next  = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid_next)
        begin
            res_ev_reg   <= res_ev_next;
            res_slot_reg <= res_slot_next;
            res_id_reg   <= res_id_next;
            res_x_reg    <= res_x_next;
            res_y_reg    <= res_y_next;
            res_last_reg <= res_last_next;
        end
    end

    // port width fitting of slot and identity
    always_comb
    begin
        slot_wide = '0;
        slot_wide[SLOT_W-1:0] = res_slot_reg;
        id_wide = '0;
        id_wide[ID_W-1:0] = res_id_reg;
    end

    assign result_valid = res_valid_reg;
    assign event_res    = res_ev_reg;
    assign slot         = slot_wide[SLOT_OUT_W-1:0];
    assign ev_marker_id = id_wide[MARKER_ID_W-1:0];
    assign ev_pos_x     = res_x_reg;
    assign ev_pos_y     = res_y_reg;
    assign last         = res_last_reg;

endmodule

// File: rtl/marker_track_table.sv
// marker_track_table: top level of the tracked-marker table.
// Instantiates mtt_controller and mtt_datapath; depends on mtt_pkg.
//
//  channel   ports                                      transfer
//  command   start, busy, cmd, marker_id, pos_x, pos_y  start && !busy at clk rise
//  result    result_valid, event_res, slot, ...,  last  result_valid, one cycle each
//  config    cfg_we, cfg_index, cfg_data                cfg_we at clk rise
//
// every command, from transfer until busy falls, reads one table entry per
// cycle through the record memory read port, then drains the scan pipeline
// and ends in the finish state.
// results follow one per cycle at most, the final one with last set.
// rst_n clears the table flags and sets the config registers to their reset values asynchronously.
// results cannot be held off by the receiver.
module marker_track_table #(
    parameter int TABLE_DEPTH = mtt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ID_BITS     = mtt_pkg::DEFAULT_ID_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [mtt_pkg::CMD_W-1:0]       cmd,
    input  logic        [mtt_pkg::MARKER_ID_W-1:0] marker_id,
    input  logic signed [mtt_pkg::POS_W-1:0]       pos_x,
    input  logic signed [mtt_pkg::POS_W-1:0]       pos_y,
    input  logic                                  cfg_we,
    input  logic        [mtt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [mtt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  result_valid,
    output logic        [mtt_pkg::EV_W-1:0]        event_res,
    output logic        [mtt_pkg::SLOT_OUT_W-1:0]  slot,
    output logic        [mtt_pkg::MARKER_ID_W-1:0] ev_marker_id,
    output logic signed [mtt_pkg::POS_W-1:0]       ev_pos_x,
    output logic signed [mtt_pkg::POS_W-1:0]       ev_pos_y,
    output logic                                  last
);
    import mtt_pkg::*;

    mtt_ctl_t    ctl;
    mtt_status_t status;

    // sequencer
    mtt_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    // table and scan datapath
    mtt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .status       (status),
        .cmd          (cmd),
        .marker_id    (marker_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .event_res    (event_res),
        .slot         (slot),
        .ev_marker_id (ev_marker_id),
        .ev_pos_x     (ev_pos_x),
        .ev_pos_y     (ev_pos_y),
        .last         (last)
    );

    // results only come out of a command in progress
    a_result_in_command: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result transfer outside a command");

    // the final result of a command is not followed straight by another
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result transfer right after the last one");

    // a command begins only on start
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // a dropped detection reports slot zero
    a_dropped_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (event_res == EV_DROPPED)) |-> (slot == '0))
        else $error("dropped event with nonzero slot");

endmodule
